### src/rtc_datetime_decode_tz_core_defines.svh
// assertion macros for the clock-chip date/time decoder
// used by rtc_datetime_decode_tz_core, no other dependencies
`ifndef RTC_DATETIME_DECODE_TZ_CORE_DEFINES_SVH
`define RTC_DATETIME_DECODE_TZ_CORE_DEFINES_SVH

// same-cycle implication, checked while out of reset
`define RDT_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, checked while out of reset
`define RDT_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

### src/rdt_pkg.sv
// shared types, register map and calendar helpers for the date/time decoder
// no dependencies
package rdt_pkg;

   localparam int CSR_ADDR_W = 4;
   localparam int CSR_DATA_W = 32;

   // register indexes (word address bits [3:2])
   localparam logic [1:0] CSR_BINARY_MODE = 2'd0;
   localparam logic [1:0] CSR_HOUR_24     = 2'd1;
   localparam logic [1:0] CSR_TZ_OFFSET   = 2'd2;

   localparam logic       BINARY_MODE_RST = 1'b1;
   localparam logic       HOUR_24_RST     = 1'b1;
   localparam logic [5:0] TZ_OFFSET_RST   = 6'h3B;   // -5

   localparam logic [7:0]  HOUR_NOON   = 8'd12;
   localparam logic [7:0]  HOURS_DAY   = 8'd24;
   localparam logic [7:0]  MONTH_DEC   = 8'd12;
   localparam logic [7:0]  YEAR_2DIGIT = 8'd100;
   localparam logic [15:0] YEAR_BASE   = 16'd2000;
   localparam logic [7:0]  BAD_MONTH_DAYS = 8'd30;

   localparam logic [7:0] MONTH_LEN [12] = '{
      8'd31, 8'd28, 8'd31, 8'd30, 8'd31, 8'd30,
      8'd31, 8'd31, 8'd30, 8'd31, 8'd30, 8'd31
   };

   typedef struct packed {
      logic [7:0] raw_second;
      logic [7:0] raw_minute;
      logic [7:0] raw_hour;
      logic [7:0] raw_day;
      logic [7:0] raw_month;
      logic [7:0] raw_year;
   } req_type;

   typedef struct packed {
      logic [7:0]  second;
      logic [7:0]  minute;
      logic [7:0]  hour;
      logic [7:0]  day;
      logic [7:0]  month;
      logic [15:0] year;
   } rsp_type;

   // high nibble * 10 + low nibble, no digit check, wraps at 8 bits
   function automatic logic [7:0] bcd_byte_decode(input logic [7:0] v);
      logic [7:0] hi;
      hi = {4'b0, v[7:4]};
      return (hi << 3) + (hi << 1) + {4'b0, v[3:0]};
   endfunction

   // leap test on the decoded year byte; the full year is 2000..2099 or 100..255
   // here, so only 100 and 200 are multiples of 100 that fail the 400 rule
   function automatic logic leap_of_byte(input logic [7:0] yb);
      logic div4;
      div4 = (yb[1:0] == 2'b00);
      if (yb < YEAR_2DIGIT) return div4;
      return div4 && (yb != 8'd100) && (yb != 8'd200);
   endfunction

   function automatic logic [7:0] month_days(input logic [7:0] m, input logic leap);
      logic [3:0] idx;
      idx = m[3:0] - 4'd1;
      if (m < 8'd1 || m > MONTH_DEC) return BAD_MONTH_DAYS;
      if (m == 8'd2 && leap) return 8'd29;
      return MONTH_LEN[idx];
   endfunction

endpackage

### src/rtc_datetime_decode_tz_core.sv
// clock-chip date/time decoder with time-zone shift, top level
// depends on rdt_pkg and rtc_datetime_decode_tz_core_defines.svh
// a request goes to the input stage, then its decoded form to the result register
// throughput: one snapshot per cycle unless stalled, set by the single
// input/result register pair; reset: synchronous, clears both valid flags
// and loads the registers to binary mode, 24-hour mode and an offset of -5 hours
`include "rtc_datetime_decode_tz_core_defines.svh"

module rtc_datetime_decode_tz_core
   import rdt_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   // request channel
   input  logic                  req_valid,
   output logic                  req_stall,
   input  req_type               req_data,
   // result channel
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output rsp_type               rsp_data,
   // register port
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready
);

   // configuration registers
   logic       binary_mode_ff, binary_mode_in;
   logic       hour_24_ff, hour_24_in;
   logic [5:0] tz_offset_ff, tz_offset_in;

   // input stage and result stage
   logic    s1_valid_ff, s1_valid_in;
   req_type s1_data_ff, s1_data_in;
   logic    rsp_valid_ff, rsp_valid_in;
   rsp_type rsp_data_ff, rsp_data_in;

   logic req_xfer, s1_move, csr_wr;

   // decode path
   logic [7:0]  sec_bin, min_bin, hr_bin, day_bin, mon_bin, yb_bin;
   logic [7:0]  hr_clk, hr_12;
   logic        pm;
   logic [15:0] year_full;
   logic        leap;
   logic signed [9:0] off_ext, nh;
   logic [7:0]  prev_mon, fwd_len, bwd_len;
   logic [7:0]  hour_out, day_out, mon_out;
   logic [15:0] year_out;

   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;

   // register writes and reads
   always_comb begin
      binary_mode_in = binary_mode_ff;
      hour_24_in     = hour_24_ff;
      tz_offset_in   = tz_offset_ff;
      csr_prdata     = '0;
      if (csr_wr) begin
         unique case (csr_paddr[3:2])
            CSR_BINARY_MODE: binary_mode_in = csr_pwdata[0];
            CSR_HOUR_24:     hour_24_in     = csr_pwdata[0];
            CSR_TZ_OFFSET:   tz_offset_in   = csr_pwdata[5:0];
            default: ;
         endcase
      end
      unique case (csr_paddr[3:2])
         CSR_BINARY_MODE: csr_prdata = {{(CSR_DATA_W-1){1'b0}}, binary_mode_ff};
         CSR_HOUR_24:     csr_prdata = {{(CSR_DATA_W-1){1'b0}}, hour_24_ff};
         CSR_TZ_OFFSET:   csr_prdata = {{(CSR_DATA_W-6){1'b0}}, tz_offset_ff};
         default:         csr_prdata = '0;
      endcase
   end

   // handshake: result register frees up when empty or taken, input stage
   // follows it, so a new transfer lands every cycle while the output drains
   assign s1_move   = !rsp_valid_ff || !rsp_stall;
   assign req_stall = s1_valid_ff && !s1_move;
   assign req_xfer  = req_valid && !req_stall;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   always_comb begin
      s1_valid_in  = s1_valid_ff;
      s1_data_in   = s1_data_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (s1_move) begin
         rsp_valid_in = s1_valid_ff;
         rsp_data_in  = '{second: sec_bin, minute: min_bin, hour: hour_out,
                          day: day_out, month: mon_out, year: year_out};
         s1_valid_in  = req_xfer;
      end
      // an empty input stage takes a transfer even while the result waits
      if (req_xfer) begin
         s1_valid_in = 1'b1;
         s1_data_in  = req_data;
      end
   end

   // BCD or binary decode; the PM flag is read before any masking
   always_comb begin
      pm = s1_data_ff.raw_hour[7];
      if (binary_mode_ff) begin
         sec_bin = s1_data_ff.raw_second;
         min_bin = s1_data_ff.raw_minute;
         hr_bin  = s1_data_ff.raw_hour;
         day_bin = s1_data_ff.raw_day;
         mon_bin = s1_data_ff.raw_month;
         yb_bin  = s1_data_ff.raw_year;
      end else begin
         sec_bin = bcd_byte_decode(s1_data_ff.raw_second);
         min_bin = bcd_byte_decode(s1_data_ff.raw_minute);
         hr_bin  = bcd_byte_decode({1'b0, s1_data_ff.raw_hour[6:0]});
         day_bin = bcd_byte_decode(s1_data_ff.raw_day);
         mon_bin = bcd_byte_decode(s1_data_ff.raw_month);
         yb_bin  = bcd_byte_decode(s1_data_ff.raw_year);
      end
   end

   // 12-hour to 24-hour: noon and midnight are the special cases
   always_comb begin
      hr_12 = {1'b0, hr_bin[6:0]};
      if (pm) begin
         if (hr_12 != HOUR_NOON) hr_12 = hr_12 + HOUR_NOON;
      end else if (hr_12 == HOUR_NOON) begin
         hr_12 = '0;
      end
      hr_clk = hour_24_ff ? hr_bin : hr_12;
   end

   // two-digit years land in 2000..2099, larger bytes pass as they are
   assign year_full = (yb_bin < YEAR_2DIGIT) ? (YEAR_BASE + {8'b0, yb_bin}) : {8'b0, yb_bin};
   assign leap      = leap_of_byte(yb_bin);

   // month lengths for both roll directions; the previous-year case only
   // ever asks for december, which ignores the leap flag
   assign prev_mon = (mon_bin > 8'd1) ? (mon_bin - 8'd1) : MONTH_DEC;
   assign fwd_len  = month_days(mon_bin, leap);
   assign bwd_len  = month_days(prev_mon, leap);

   assign off_ext = {{4{tz_offset_ff[5]}}, tz_offset_ff};
   assign nh      = $signed({2'b00, hr_clk}) + off_ext;

   // time-zone shift, rolling the date by at most one day
   always_comb begin
      hour_out = hr_clk;
      day_out  = day_bin;
      mon_out  = mon_bin;
      year_out = year_full;
      if (tz_offset_ff != '0) begin
         if (nh < 0) begin
            hour_out = 8'(nh + 10'sd24);
            if (day_bin > 8'd1) begin
               day_out = day_bin - 8'd1;
            end else begin
               mon_out = prev_mon;
               if (mon_bin <= 8'd1) year_out = year_full - 16'd1;
               day_out = bwd_len;
            end
         end else if (nh >= $signed({2'b00, HOURS_DAY})) begin
            hour_out = 8'(nh - 10'sd24);
            if (day_bin < fwd_len) begin
               day_out = day_bin + 8'd1;
            end else begin
               day_out = 8'd1;
               if (mon_bin < MONTH_DEC) begin
                  mon_out = mon_bin + 8'd1;
               end else begin
                  mon_out  = 8'd1;
                  year_out = year_full + 16'd1;
               end
            end
         end else begin
            hour_out = nh[7:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         binary_mode_ff <= BINARY_MODE_RST;
         hour_24_ff     <= HOUR_24_RST;
         tz_offset_ff   <= TZ_OFFSET_RST;
         s1_valid_ff    <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         binary_mode_ff <= binary_mode_in;
         hour_24_ff     <= hour_24_in;
         tz_offset_ff   <= tz_offset_in;
         s1_valid_ff    <= s1_valid_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_data_ff  <= s1_data_in;
      rsp_data_ff <= rsp_data_in;
   end

   `RDT_ASSERT_NOW(a_stall_needs_item, clock, reset, req_stall, s1_valid_ff,
      "request stalled with an empty input stage")
   `RDT_ASSERT_NEXT(a_xfer_fills_stage, clock, reset, req_valid && !req_stall, s1_valid_ff,
      "request transfer did not reach the input stage")
   `RDT_ASSERT_NOW(a_month_stays_valid, clock, reset,
      s1_valid_ff && mon_bin >= 8'd1 && mon_bin <= MONTH_DEC,
      mon_out >= 8'd1 && mon_out <= MONTH_DEC, "valid month rolled out of range")
   `RDT_ASSERT_NOW(a_zero_offset_passes, clock, reset, s1_valid_ff && tz_offset_ff == '0,
      hour_out == hr_clk && day_out == day_bin && year_out == year_full,
      "zero offset changed the date or time")

endmodule

### sim/rtc_datetime_decode_tz_core_tb.sv
// self-checking testbench for the clock-chip date/time decoder with time-zone shift
// depends on rdt_pkg for the payload types and register indexes, drives rtc_datetime_decode_tz_core
module rtc_datetime_decode_tz_core_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import rdt_pkg::*;

   localparam int PHASES           = 8;
   localparam int RANDOM_PER_PHASE = 190;
   localparam int WATCHDOG_CYCLES  = 4000;
   localparam int SETTLE_CYCLES    = 4;

   // per-phase register settings, phase 0 in the low bits; the last phase is drawn at random
   localparam logic [7:0]  PHASE_BIN = 8'b00101100;
   localparam logic [7:0]  PHASE_H24 = 8'b01001010;
   localparam logic [47:0] PHASE_TZ  = {6'h00, 6'h3F, 6'h01, 6'h20, 6'h1F, 6'h00, 6'h17, 6'h29};

   // scoreboard: predicts the local date/time for each snapshot and checks results in order
   class datetime_scoreboard;
      rsp_type            predicted_dates[$];
      logic               binary_bytes;
      logic               clock_24h;
      logic signed [5:0]  tz_shift;
      int                 mismatches;
      int                 checked;

      function new();
         binary_bytes = 1'b1;
         clock_24h    = 1'b1;
         tz_shift     = -6'sd5;
         mismatches   = 0;
         checked      = 0;
      endfunction

      function void set_reg(logic [1:0] idx, logic [31:0] value);
         case (idx)
            CSR_BINARY_MODE: binary_bytes = value[0];
            CSR_HOUR_24:     clock_24h    = value[0];
            CSR_TZ_OFFSET:   tz_shift     = value[5:0];
            default: ;
         endcase
      endfunction

      static function int month_length(int m, int y);
         bit leap;
         leap = ((y % 4) == 0 && (y % 100) != 0) || (y % 400) == 0;
         if (m < 1 || m > 12) return 30;
         case (m)
            2:            return leap ? 29 : 28;
            4, 6, 9, 11:  return 30;
            default:      return 31;
         endcase
      endfunction

      static function int from_bcd(int v);
         return ((v >> 4) * 10 + (v & 15)) & 255;
      endfunction

      function rsp_type decode_snapshot(req_type r);
         int      sec, mins, hr, dy, mon, yb, yr, off, sum;
         bit      pm;
         rsp_type res;
         sec  = r.raw_second;
         mins = r.raw_minute;
         hr   = r.raw_hour;
         dy   = r.raw_day;
         mon  = r.raw_month;
         yb   = r.raw_year;
         // pm flag comes from the raw byte, before any bcd decode
         pm   = r.raw_hour[7];
         if (!binary_bytes) begin
            sec  = from_bcd(sec);
            mins = from_bcd(mins);
            hr   = from_bcd(hr & 'h7F);
            dy   = from_bcd(dy);
            mon  = from_bcd(mon);
            yb   = from_bcd(yb);
         end
         if (!clock_24h) begin
            hr = hr & 'h7F;
            if (pm) begin
               if (hr != 12) hr = (hr + 12) & 'hFF;
            end else if (hr == 12) begin
               hr = 0;
            end
         end
         yr  = (yb < 100) ? yb + 2000 : yb;
         off = tz_shift;
         if (off != 0) begin
            sum = hr + off;
            if (sum < 0) begin
               hr = (sum + 24) & 'hFF;
               if (dy > 1) begin
                  dy = dy - 1;
               end else begin
                  if (mon > 1) begin
                     mon = mon - 1;
                  end else begin
                     mon = 12;
                     yr  = (yr - 1) & 'hFFFF;
                  end
                  dy = month_length(mon, yr);
               end
            end else if (sum >= 24) begin
               hr = (sum - 24) & 'hFF;
               if (dy < month_length(mon, yr)) begin
                  dy = dy + 1;
               end else begin
                  dy = 1;
                  if (mon < 12) begin
                     mon = mon + 1;
                  end else begin
                     mon = 1;
                     yr  = (yr + 1) & 'hFFFF;
                  end
               end
            end else begin
               hr = sum;
            end
         end
         res.second = sec[7:0];
         res.minute = mins[7:0];
         res.hour   = hr[7:0];
         res.day    = dy[7:0];
         res.month  = mon[7:0];
         res.year   = yr[15:0];
         return res;
      endfunction

      function void note_request(req_type r);
         predicted_dates.push_back(decode_snapshot(r));
      endfunction

      function void compare_field(string name, logic [15:0] want, logic [15:0] got);
         if (want !== got) begin
            mismatches++;
            if (mismatches <= 40)
               $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
         end
      endfunction

      function void check_result(rsp_type got);
         rsp_type want;
         if (predicted_dates.size() == 0) begin
            mismatches++;
            $display("%0t: result with nothing outstanding, expected none, actual %h", $time, got);
            return;
         end
         want = predicted_dates.pop_front();
         checked++;
         compare_field("second", 16'(want.second), 16'(got.second));
         compare_field("minute", 16'(want.minute), 16'(got.minute));
         compare_field("hour",   16'(want.hour),   16'(got.hour));
         compare_field("day",    16'(want.day),    16'(got.day));
         compare_field("month",  16'(want.month),  16'(got.month));
         compare_field("year",   want.year,        got.year);
      endfunction
   endclass

   // dut signals, all inputs known from time zero
   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_stall;
   req_type               req_data = '0;
   logic                  rsp_valid;
   logic                  rsp_stall = 1'b0;
   rsp_type               rsp_data;
   logic                  csr_psel = 1'b0;
   logic                  csr_penable = 1'b0;
   logic                  csr_pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_paddr = '0;
   logic [CSR_DATA_W-1:0] csr_pwdata = '0;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   datetime_scoreboard sb;
   int                 items_sent = 0;
   int                 quiet_cycles = 0;
   int                 stall_mode = 0;
   int                 stall_left = 0;
   int                 stall_tick = 0;
   bit                 moved;

   rtc_datetime_decode_tz_core uut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_data    (rsp_data),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   initial begin
      forever #6 clock = ~clock;
   end

   // receiver back-pressure: switches between free-running, light, heavy and periodic stalls
   always @(negedge clock) begin
      if (stall_left == 0) begin
         stall_mode = $urandom_range(0, 3);
         stall_left = $urandom_range(20, 200);
      end
      stall_left--;
      stall_tick++;
      case (stall_mode)
         0:       rsp_stall <= 1'b0;
         1:       rsp_stall <= ($urandom_range(0, 3) == 0);
         2:       rsp_stall <= ($urandom_range(0, 9) < 7);
         default: rsp_stall <= ((stall_tick % 5) < 2);
      endcase
   end

   // result monitor and watchdog; a cycle with no transfer on either channel counts as quiet
   always @(posedge clock) begin
      if (!reset) begin
         moved = 1'b0;
         if (rsp_valid && !rsp_stall) begin
            sb.check_result(rsp_data);
            moved = 1'b1;
         end
         if (req_valid && !req_stall) moved = 1'b1;
         quiet_cycles = moved ? 0 : quiet_cycles + 1;
         if (quiet_cycles >= WATCHDOG_CYCLES) begin
            $display("%0t: no transfer for %0d cycles, %0d results outstanding",
                     $time, quiet_cycles, sb.predicted_dates.size());
            $display("rtc_datetime_decode_tz_core_tb: FAIL");
            $finish;
         end
      end
   end

   function automatic req_type snapshot(logic [7:0] s, logic [7:0] mi, logic [7:0] h,
                                        logic [7:0] d, logic [7:0] mo, logic [7:0] y);
      return {s, mi, h, d, mo, y};
   endfunction

   function automatic logic [7:0] to_bcd(int v);
      return 8'(((v / 10) << 4) | (v % 10));
   endfunction

   // mostly plausible dates in the current encoding, biased to month edges; the rest raw noise
   function automatic req_type random_snapshot(bit bin, bit h24);
      int      s, mi, h, d, mo, y, mlen;
      bit      pm;
      req_type r;
      if ($urandom_range(0, 9) < 3) begin
         r.raw_second = 8'($urandom_range(0, 255));
         r.raw_minute = 8'($urandom_range(0, 255));
         r.raw_hour   = 8'($urandom_range(0, 255));
         r.raw_day    = 8'($urandom_range(0, 255));
         r.raw_month  = 8'($urandom_range(0, 255));
         r.raw_year   = 8'($urandom_range(0, 255));
         return r;
      end
      s  = $urandom_range(0, 59);
      mi = $urandom_range(0, 59);
      mo = ($urandom_range(0, 19) == 0) ? (($urandom_range(0, 1) == 0) ? 0 : 13) :
           $urandom_range(1, 12);
      y  = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 165) : $urandom_range(0, 99);
      mlen = datetime_scoreboard::month_length(mo, (y < 100) ? y + 2000 : y);
      case ($urandom_range(0, 9))
         0, 1, 2, 3: d = 1;
         4, 5, 6, 7: d = mlen;
         8:          d = $urandom_range(1, mlen);
         default:    d = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, mlen);
      endcase
      pm = 1'($urandom_range(0, 1));
      h  = h24 ? $urandom_range(0, 23) : $urandom_range(1, 12);
      if (bin) begin
         r = snapshot(8'(s), 8'(mi), 8'(h), 8'(d), 8'(mo), 8'(y));
      end else begin
         r = snapshot(to_bcd(s), to_bcd(mi), to_bcd(h), to_bcd(d), to_bcd(mo),
                      (y < 100) ? to_bcd(y) : 8'($urandom_range('hA0, 'hFF)));
      end
      if (!h24) r.raw_hour[7] = pm;
      return r;
   endfunction

   // sender: valid is raised at the falling edge and held until the transfer
   task automatic send_item(input req_type item);
      @(negedge clock);
      req_valid <= 1'b1;
      req_data  <= item;
      do @(posedge clock); while (!(req_valid && !req_stall));
      sb.note_request(item);
      items_sent++;
   endtask

   // gap cycles; the payload is scrambled while valid is low
   task automatic idle_sender(input int cycles);
      repeat (cycles) begin
         @(negedge clock);
         req_valid <= 1'b0;
         req_data  <= {16'($urandom()), 32'($urandom())};
      end
   endtask

   // hold off until every outstanding result has come back, then let the pipeline settle
   task automatic drain_results();
      idle_sender(1);
      while (sb.predicted_dates.size() != 0) idle_sender(1);
      idle_sender(SETTLE_CYCLES);
   endtask

   // apb write: setup cycle, then access cycle until pready
   task automatic write_reg(input logic [1:0] idx, input logic [31:0] value);
      @(negedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= value;
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      sb.set_reg(idx, value);
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'($urandom_range(0, 1));
      csr_pwdata  <= $urandom();
   endtask

   // random items in bursts, gaps ranging from none to long
   task automatic run_random(input int count);
      int sent, burst, gap;
      sent = 0;
      while (sent < count) begin
         burst = $urandom_range(1, 24);
         for (int i = 0; i < burst && sent < count; i++) begin
            send_item(random_snapshot(sb.binary_bytes, sb.clock_24h));
            sent++;
         end
         case ($urandom_range(0, 9))
            0, 1, 2, 3: gap = 0;
            4, 5, 6, 7: gap = $urandom_range(1, 3);
            8:          gap = $urandom_range(4, 12);
            default:    gap = $urandom_range(20, 40);
         endcase
         if (gap > 0) idle_sender(gap);
      end
   endtask

   initial begin
      logic [31:0] wdata;
      logic        bin, h24;
      logic [5:0]  tz;
      sb = new();
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // reset settings: binary bytes, 24-hour, offset -5
      send_item(snapshot(8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00));  // day and month zero
      send_item(snapshot(8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF));  // all ones, forward wrap
      send_item(snapshot(59, 59, 0, 1, 1, 0));        // new year's day rolls back a year
      send_item(snapshot(0, 0, 2, 1, 3, 0));          // 2000 leap, back to feb 29
      send_item(snapshot(0, 0, 2, 1, 3, 100));        // year 100 not leap
      send_item(snapshot(0, 0, 2, 1, 3, 4));          // 2004 leap
      send_item(snapshot(0, 0, 2, 1, 3, 1));          // 2001 common year
      send_item(snapshot(0, 0, 5, 10, 6, 20));        // lands exactly on midnight
      send_item(snapshot(0, 0, 4, 10, 6, 20));        // one hour short of midnight
      send_item(snapshot(0, 0, 8'h80, 1, 1, 99));     // hour bit 7 kept in 24-hour binary
      send_item(snapshot(0, 0, 29, 31, 12, 99));      // new year's eve forward into 2100
      send_item(snapshot(0, 0, 29, 30, 13, 5));       // invalid month counts 30 days
      send_item(snapshot(0, 0, 29, 28, 2, 0));        // feb 28 leap year
      send_item(snapshot(0, 0, 29, 28, 2, 1));        // feb 28 common year
      send_item(snapshot(0, 0, 0, 1, 14, 50));        // back into an invalid month
      send_item(snapshot(0, 0, 0, 0, 5, 10));         // day zero rolls back
      run_random(RANDOM_PER_PHASE);

      for (int p = 0; p < PHASES; p++) begin
         drain_results();
         bin = PHASE_BIN[p];
         h24 = PHASE_H24[p];
         tz  = PHASE_TZ[p*6 +: 6];
         if (p == PHASES - 1) begin
            bin = 1'($urandom_range(0, 1));
            h24 = 1'($urandom_range(0, 1));
            tz  = 6'($urandom_range(0, 63));
         end
         wdata = $urandom();
         wdata[0] = bin;
         write_reg(CSR_BINARY_MODE, wdata);
         wdata = $urandom();
         wdata[0] = h24;
         write_reg(CSR_HOUR_24, wdata);
         wdata = $urandom();
         wdata[5:0] = tz;
         write_reg(CSR_TZ_OFFSET, wdata);

         if (p == 0) begin
            // bcd, 12-hour, offset -23
            send_item(snapshot(8'h59, 8'h59, 8'h12, 8'h01, 8'h01, 8'h00));  // 12 am is midnight
            send_item(snapshot(8'h00, 8'h30, 8'h92, 8'h01, 8'h03, 8'h00));  // 12 pm is noon
            send_item(snapshot(8'h00, 8'h00, 8'h81, 8'h15, 8'h06, 8'h99));  // 1 pm
            send_item(snapshot(8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF));  // non-digit nibbles
            send_item(snapshot(8'h99, 8'h99, 8'h99, 8'h99, 8'h99, 8'h99));  // largest digits
         end

         if (p == 3) begin
            // mid-phase hold-off until the block is empty
            run_random(RANDOM_PER_PHASE / 2);
            drain_results();
            run_random(RANDOM_PER_PHASE - RANDOM_PER_PHASE / 2);
         end else begin
            run_random(RANDOM_PER_PHASE);
         end
      end

      drain_results();
      idle_sender(10);

      $display("sent %0d snapshots over %0d register settings, checked %0d results",
               items_sent, PHASES + 1, sb.checked);
      $display("mismatches %0d, results still outstanding %0d",
               sb.mismatches, sb.predicted_dates.size());
      if (sb.mismatches == 0 && sb.predicted_dates.size() == 0) begin
         $display("rtc_datetime_decode_tz_core_tb: PASS");
      end else begin
         $display("rtc_datetime_decode_tz_core_tb: FAIL");
      end
      $finish;
   end

endmodule
